>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; take in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define CFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define CFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/cfp_pkg.sv
// Types, codes and the CRC-16/X.25 byte update for the framed packet parser.
// No dependencies; used by cfp_step, the top level, the checker and the testbench.
package cfp_pkg;

    // Parser phases; codes 6 and 7 are unused and decode as idle
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRCL = 3'd4,
        PH_CRCH = 3'd5
    } phase_t;

    // Event codes reported with each result
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_HEADER     = 3'd1,
        EV_PAYLOAD    = 3'd2,
        EV_ACCEPT     = 3'd3,
        EV_LEN_REJECT = 3'd4,
        EV_CRCL_BAD   = 3'd5,
        EV_CRCH_BAD   = 3'd6
    } event_t;

    // Configuration register indexes
    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;

    localparam logic [7:0]  MAGIC_RESET   = 8'h00;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd32;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;

    typedef struct packed {
        logic [7:0] magic;
        logic [7:0] max_length;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] crc;
        logic [7:0]  byte_count;
        logic [7:0]  held_length;
        logic [7:0]  held_type;
    } parse_state_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [7:0] payload_index;
    } result_t;

    // One byte of the X.25 accumulate (reflected 0x1021)
    function automatic logic [15:0] crc_x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

>>> rtl/core/crc_checked_frame_parser.sv
// Framed serial packet parser with CRC-16 check (reflected 0x1021, seed 0xFFFF, no final XOR): top level.
// Depends on cfp_pkg and cfp_step; holds parser state, config and result/skid registers.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_rx_byte               | in
//   result  | m_valid m_ready m_event_res m_data_byte | out
//           | m_frame_type m_frame_length             |
//           | m_payload_index                         |
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// One byte per cycle while s_ready is high; each accepted byte gives one registered result.
// The parse step (CRC byte update and phase decode) is combinational logic.
// A one-entry skid register keeps s_ready registered; it holds a result while the output stalls.
// Reset (aresetn low, synchronous) empties both result registers and restores
// the parser to hunting the marker byte; config writes are always accepted.
module crc_checked_frame_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_frame_type,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_payload_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfp_pkg::cfg_t         cfg_reg;
    cfp_pkg::parse_state_t state_reg;
    cfp_pkg::parse_state_t state_next;
    cfp_pkg::result_t      step_res;
    cfp_pkg::result_t      out_reg;
    cfp_pkg::result_t      out_next;
    cfp_pkg::result_t      skid_reg;
    cfp_pkg::result_t      skid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic                  in_xfer;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic      <= cfp_pkg::MAGIC_RESET;
            cfg_reg.max_length <= cfp_pkg::MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == cfp_pkg::REG_MAGIC) begin
                cfg_reg.magic <= cfg_data;
            end
            if (cfg_index == cfp_pkg::REG_MAX_LEN) begin
                cfg_reg.max_length <= cfg_data;
            end
        end
    end

    cfp_step u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .rx_byte (s_rx_byte),
        .st_next (state_next),
        .res     (step_res)
    );

    // Advance the parser on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= cfp_pkg::PH_IDLE;
            state_reg.crc         <= cfp_pkg::CRC_SEED;
            state_reg.byte_count  <= 8'd0;
            state_reg.held_length <= 8'd0;
            state_reg.held_type   <= 8'd0;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    // Result register and skid entry: drain the skid first, keep order
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = step_res;
                skid_valid_next = in_xfer;
            end else begin
                out_next       = step_res;
                out_valid_next = in_xfer;
            end
        end else if (in_xfer) begin
            skid_next       = step_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_event_res     = out_reg.event_res;
    assign m_data_byte     = out_reg.data_byte;
    assign m_frame_type    = out_reg.frame_type;
    assign m_frame_length  = out_reg.frame_length;
    assign m_payload_index = out_reg.payload_index;

endmodule

>>> rtl/core/cfp_step.sv
// One parse step: next parser state and the result for one received byte.
// Depends on cfp_pkg (phase and event codes, state/result structs, CRC update).
module cfp_step (
    input  cfp_pkg::cfg_t         cfg,
    input  cfp_pkg::parse_state_t st,
    input  logic [7:0]            rx_byte,
    output cfp_pkg::parse_state_t st_next,
    output cfp_pkg::result_t      res
);

    logic [15:0]     crc_upd;
    logic [7:0]      count_inc;
    logic            len_reject;
    logic            low_match;
    logic            high_match;
    logic            is_magic;
    logic            last_payload;
    cfp_pkg::phase_t phase_next;
    logic [15:0]     crc_next;
    logic [7:0]      count_next;
    logic [7:0]      len_next;
    logic [7:0]      type_next;

    // Shared decode of the incoming byte
    assign crc_upd      = cfp_pkg::crc_x25_step(st.crc, rx_byte);
    assign count_inc    = st.byte_count + 8'd1;
    assign len_reject   = rx_byte > cfg.max_length;
    assign low_match    = rx_byte == st.crc[7:0];
    assign high_match   = rx_byte == st.crc[15:8];
    assign is_magic     = rx_byte == cfg.magic;
    assign last_payload = count_inc >= st.held_length;

    // Next phase
    always_comb begin
        case (st.phase)
            cfp_pkg::PH_LEN: begin
                phase_next = len_reject ? cfp_pkg::PH_IDLE : cfp_pkg::PH_TYPE;
            end
            cfp_pkg::PH_TYPE: begin
                phase_next = (st.held_length == 8'd0) ? cfp_pkg::PH_CRCL : cfp_pkg::PH_DATA;
            end
            cfp_pkg::PH_DATA: begin
                phase_next = last_payload ? cfp_pkg::PH_CRCL : cfp_pkg::PH_DATA;
            end
            cfp_pkg::PH_CRCL: begin
                phase_next = low_match ? cfp_pkg::PH_CRCH : cfp_pkg::PH_IDLE;
            end
            cfp_pkg::PH_CRCH: begin
                phase_next = cfp_pkg::PH_IDLE;
            end
            default: begin
                phase_next = is_magic ? cfp_pkg::PH_LEN : cfp_pkg::PH_IDLE;
            end
        endcase
    end

    // Datapath updates and the reported event
    always_comb begin
        crc_next          = st.crc;
        count_next        = st.byte_count;
        len_next          = st.held_length;
        type_next         = st.held_type;
        res.event_res     = cfp_pkg::EV_NONE;
        res.data_byte     = 8'h00;
        res.payload_index = 8'h00;
        case (st.phase)
            cfp_pkg::PH_LEN: begin
                if (len_reject) begin
                    res.event_res = cfp_pkg::EV_LEN_REJECT;
                end else begin
                    len_next = rx_byte;
                    crc_next = crc_upd;
                end
            end
            cfp_pkg::PH_TYPE: begin
                type_next     = rx_byte;
                crc_next      = crc_upd;
                res.event_res = cfp_pkg::EV_HEADER;
            end
            cfp_pkg::PH_DATA: begin
                crc_next          = crc_upd;
                count_next        = count_inc;
                res.event_res     = cfp_pkg::EV_PAYLOAD;
                res.data_byte     = rx_byte;
                res.payload_index = st.byte_count;
            end
            cfp_pkg::PH_CRCL: begin
                if (!low_match) begin
                    res.event_res = cfp_pkg::EV_CRCL_BAD;
                end
            end
            cfp_pkg::PH_CRCH: begin
                res.event_res = high_match ? cfp_pkg::EV_ACCEPT : cfp_pkg::EV_CRCH_BAD;
            end
            default: begin
                // restart the frame on the marker byte
                if (is_magic) begin
                    count_next = 8'd0;
                    crc_next   = cfp_pkg::CRC_SEED;
                end
            end
        endcase
        res.frame_type   = type_next;
        res.frame_length = (res.event_res == cfp_pkg::EV_LEN_REJECT) ? rx_byte : len_next;
    end

    assign st_next = '{
        phase:       phase_next,
        crc:         crc_next,
        byte_count:  count_next,
        held_length: len_next,
        held_type:   type_next
    };

endmodule

>>> rtl/core/cfp_checker.sv
// Port-level checks for the framed packet parser, bound to the top level.
// Depends on cfp_pkg (event codes) and assert_macros.svh.
`include "assert_macros.svh"

module cfp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_res,
    input logic [7:0] m_data_byte,
    input logic [7:0] m_frame_length,
    input logic [7:0] m_payload_index
);

    // Only the defined event codes appear
    `CFP_ASSERT_NOW(a_event_code, aclk, aresetn, m_valid, m_event_res != 3'd7)

    // Data and index are zero outside payload results
    `CFP_ASSERT_NOW(a_non_payload_zero, aclk, aresetn, m_valid && (m_event_res != cfp_pkg::EV_PAYLOAD), (m_data_byte == 8'h00) && (m_payload_index == 8'h00))

    // A payload byte always lies inside the announced length
    `CFP_ASSERT_NOW(a_index_in_frame, aclk, aresetn, m_valid && (m_event_res == cfp_pkg::EV_PAYLOAD), m_payload_index < m_frame_length)

    // A stalled result holds
    `CFP_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_event_res) && $stable(m_data_byte) && $stable(m_payload_index))

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for crc_checked_frame_parser: serial bytes and register writes in,
// each result transfer compared field by field with a cycle-free parser and CRC model.
// Depends on cfp_pkg (types, codes, reset values) and the crc_checked_frame_parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600000;

    // Frame damage kinds for generated traffic
    localparam int FRAME_GOOD   = 0;
    localparam int FRAME_BAD_LO = 1;
    localparam int FRAME_BAD_HI = 2;
    localparam int FRAME_CUT    = 3;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_event_res;
    logic [7:0] m_data_byte;
    logic [7:0] m_frame_type;
    logic [7:0] m_frame_length;
    logic [7:0] m_payload_index;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = cfp_pkg::REG_MAGIC;
    logic [7:0] cfg_data = 8'h00;

    // Parser model state and its copy of the registers
    cfp_pkg::phase_t ph = cfp_pkg::PH_IDLE;
    logic [15:0]     crc_acc = cfp_pkg::CRC_SEED;
    logic [7:0]      n_taken = 8'd0;
    logic [7:0]      len_held = 8'd0;
    logic [7:0]      type_held = 8'd0;
    logic [7:0]      magic_cfg = cfp_pkg::MAGIC_RESET;
    logic [7:0]      max_len_cfg = cfp_pkg::MAX_LEN_RESET;

    logic [7:0]       rx_stream[$];
    logic [7:0]       body_q[$];
    cfp_pkg::result_t predicted_results[$];

    int          stim_count = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_gap = 0;
    int unsigned sink_wait = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    crc_checked_frame_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_data_byte     (m_data_byte),
        .m_frame_type    (m_frame_type),
        .m_frame_length  (m_frame_length),
        .m_payload_index (m_payload_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Reflected 0x1021 CRC, shifted one bit at a time
    function automatic logic [15:0] crc16_x25(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ 16'h8408) : (v >> 1);
        end
        return v;
    endfunction

    // Advance the parser model by one received byte and return the result it gives
    function automatic cfp_pkg::result_t parse_byte(input logic [7:0] c);
        cfp_pkg::result_t r;
        r = '0;
        r.event_res = cfp_pkg::EV_NONE;
        case (ph)
            cfp_pkg::PH_LEN: begin
                if (c > max_len_cfg) begin
                    r.event_res = cfp_pkg::EV_LEN_REJECT;
                    ph = cfp_pkg::PH_IDLE;
                end else begin
                    len_held = c;
                    crc_acc = crc16_x25(crc_acc, c);
                    ph = cfp_pkg::PH_TYPE;
                end
            end
            cfp_pkg::PH_TYPE: begin
                type_held = c;
                crc_acc = crc16_x25(crc_acc, c);
                r.event_res = cfp_pkg::EV_HEADER;
                ph = (len_held == 8'd0) ? cfp_pkg::PH_CRCL : cfp_pkg::PH_DATA;
            end
            cfp_pkg::PH_DATA: begin
                crc_acc = crc16_x25(crc_acc, c);
                r.event_res = cfp_pkg::EV_PAYLOAD;
                r.data_byte = c;
                r.payload_index = n_taken;
                n_taken = n_taken + 8'd1;
                if (n_taken >= len_held) ph = cfp_pkg::PH_CRCL;
            end
            cfp_pkg::PH_CRCL: begin
                if (c == crc_acc[7:0]) begin
                    ph = cfp_pkg::PH_CRCH;
                end else begin
                    r.event_res = cfp_pkg::EV_CRCL_BAD;
                    ph = cfp_pkg::PH_IDLE;
                end
            end
            cfp_pkg::PH_CRCH: begin
                r.event_res = (c == crc_acc[15:8]) ? cfp_pkg::EV_ACCEPT : cfp_pkg::EV_CRCH_BAD;
                ph = cfp_pkg::PH_IDLE;
            end
            default: begin
                ph = cfp_pkg::PH_IDLE;
                if (c == magic_cfg) begin
                    ph = cfp_pkg::PH_LEN;
                    n_taken = 8'd0;
                    crc_acc = cfp_pkg::CRC_SEED;
                end
            end
        endcase
        r.frame_type = type_held;
        r.frame_length = (r.event_res == cfp_pkg::EV_LEN_REJECT) ? c : len_held;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    // Byte source: predict on each transfer, then hold, idle or launch the next byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) predicted_results.push_back(parse_byte(s_rx_byte));
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (rx_stream.size() != 0) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_stream.pop_front();
                    src_gap <= src_idle_en ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: check each transfer against the oldest prediction, stall at random
    always @(posedge aclk) begin
        cfp_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: event_res %0d", m_event_res);
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (m_event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res, m_event_res);
                        mismatch_count++;
                    end
                    if (m_data_byte !== want.data_byte) begin
                        $error("data_byte: expected %0d, got %0d", want.data_byte, m_data_byte);
                        mismatch_count++;
                    end
                    if (m_frame_type !== want.frame_type) begin
                        $error("frame_type: expected %0d, got %0d",
                               want.frame_type, m_frame_type);
                        mismatch_count++;
                    end
                    if (m_frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, m_frame_length);
                        mismatch_count++;
                    end
                    if (m_payload_index !== want.payload_index) begin
                        $error("payload_index: expected %0d, got %0d",
                               want.payload_index, m_payload_index);
                        mismatch_count++;
                    end
                end
            end
            if (sink_wait != 0) begin
                m_ready <= 1'b0;
                sink_wait <= sink_wait - 1;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                sink_wait <= pick_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** crc_checked_frame_parser: FAILED **");
            $finish;
        end
    end

    // Wait until no byte is pending or in flight and every result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || predicted_results.size() != 0);
    endtask

    // One register write transfer; the model takes the value at the same edge
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == cfp_pkg::REG_MAGIC) magic_cfg = val;
        else if (idx == cfp_pkg::REG_MAX_LEN) max_len_cfg = val;
        cfg_valid <= 1'b0;
    endtask

    // Queue one frame with a valid or damaged CRC; payload comes from body_q, then random
    task automatic queue_frame(input logic [7:0] marker, input logic [7:0] len,
                               input logic [7:0] ftype, input int fault);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          keep;
        bytes.push_back(marker);
        bytes.push_back(len);
        bytes.push_back(ftype);
        crc = crc16_x25(cfp_pkg::CRC_SEED, len);
        crc = crc16_x25(crc, ftype);
        for (int i = 0; i < int'(len); i++) begin
            if (body_q.size() != 0) b = body_q.pop_front();
            else if ($urandom_range(0, 15) == 0) b = marker;
            else b = 8'($urandom_range(0, 255));
            crc = crc16_x25(crc, b);
            bytes.push_back(b);
        end
        bytes.push_back((fault == FRAME_BAD_LO) ? crc[7:0] ^ 8'($urandom_range(1, 255))
                                                : crc[7:0]);
        bytes.push_back((fault == FRAME_BAD_HI) ? crc[15:8] ^ 8'($urandom_range(1, 255))
                                                : crc[15:8]);
        keep = (fault == FRAME_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
        for (int i = 0; i < keep; i++) rx_stream.push_back(bytes[i]);
        stim_count += keep;
    endtask

    // Reprogram both registers, bring the parser back to hunting, then queue random traffic
    task automatic run_phase(input logic [7:0] marker, input logic [7:0] limit,
                             input bit src_en, input bit sink_en, input int quota);
        int         start;
        int         r;
        int         n;
        int         len_top;
        logic [7:0] len;
        wait_drained();
        write_reg(cfp_pkg::REG_MAGIC, marker);
        write_reg(cfp_pkg::REG_MAX_LEN, limit);
        src_idle_en = src_en;
        sink_idle_en = sink_en;
        // flush a frame left open by the previous phase
        while (ph != cfp_pkg::PH_IDLE) begin
            rx_stream.push_back(~marker);
            wait_drained();
        end
        start = stim_count;
        // open with a frame at exactly the largest length
        queue_frame(marker, limit, 8'($urandom_range(0, 255)), FRAME_GOOD);
        len_top = (limit < 12) ? int'(limit) : 12;
        while (stim_count - start < quota) begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, limit))
                                               : 8'($urandom_range(0, len_top));
            if (r < 64) begin
                queue_frame(marker, len, 8'($urandom_range(0, 255)), FRAME_GOOD);
            end else if (r < 74) begin
                queue_frame(marker, len, 8'($urandom_range(0, 255)), FRAME_BAD_LO);
            end else if (r < 82) begin
                queue_frame(marker, len, 8'($urandom_range(0, 255)), FRAME_BAD_HI);
            end else if (r < 88 && limit != 8'd255) begin
                rx_stream.push_back(marker);
                rx_stream.push_back(8'($urandom_range(int'(limit) + 1, 255)));
                stim_count += 2;
            end else if (r < 94) begin
                queue_frame(marker, len, 8'($urandom_range(0, 255)), FRAME_CUT);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) rx_stream.push_back(8'($urandom_range(0, 255)));
                stim_count += n;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset register values: noise while hunting
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h5A);
        // zero length goes straight to the CRC bytes
        queue_frame(cfp_pkg::MAGIC_RESET, 8'd0, 8'hFF, FRAME_GOOD);
        // length one above the limit
        rx_stream.push_back(cfp_pkg::MAGIC_RESET);
        rx_stream.push_back(cfp_pkg::MAX_LEN_RESET + 8'd1);
        // marker byte inside the payload, both byte extremes
        body_q.push_back(cfp_pkg::MAGIC_RESET);
        body_q.push_back(8'hFF);
        queue_frame(cfp_pkg::MAGIC_RESET, 8'd2, 8'h00, FRAME_GOOD);
        // bad CRC low byte, then bad CRC high byte
        queue_frame(cfp_pkg::MAGIC_RESET, 8'd1, 8'h3C, FRAME_BAD_LO);
        queue_frame(cfp_pkg::MAGIC_RESET, 8'd0, 8'hC3, FRAME_BAD_HI);

        // Random part over several register settings and idle profiles
        run_phase(8'h7E, 8'd16, 1'b1, 1'b1, 190);
        run_phase(8'hFF, 8'd0, 1'b1, 1'b0, 110);
        run_phase(8'($urandom_range(0, 255)), 8'd255, 1'b0, 1'b1, 320);
        run_phase(8'h00, 8'($urandom_range(1, 64)), 1'b0, 1'b0, 210);
        run_phase(8'($urandom_range(0, 255)), 8'd32, 1'b1, 1'b1, 270);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("** crc_checked_frame_parser: PASSED **");
        end else begin
            $display("** crc_checked_frame_parser: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cfp_pkg.sv
rtl/core/cfp_step.sv
rtl/core/crc_checked_frame_parser.sv
rtl/core/cfp_checker.sv
test/tb_top.sv
